// ----- hdl/isr_pkg.sv -----
// Shared types and constants for the integer square root block.
// Holds the controller state type and the command/status structs.
// No dependencies.
package isr_pkg;

   // Default radicand datapath width
   localparam int unsigned WIDTH_DEF = 32;
   // Fixed field widths of the ports
   localparam int unsigned VALUE_W = 32;
   localparam int unsigned ROOT_W  = 16;

   // Controller states
   typedef enum logic [2:0] {
      S_IDLE,
      S_MID,
      S_SQR,
      S_CMP,
      S_DONE
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic load;      // capture radicand, reset bounds
      logic calc_mid;  // form midpoint and adjacency flag
      logic square;    // square the midpoint
      logic update;    // move one bound
      logic out_load;  // move answer into output register
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic trivial;   // incoming radicand is 0 or 1
      logic adjacent;  // bounds differ by at most one
      logic equal;     // midpoint squared equals radicand
   } status_type;

endpackage

// ----- hdl/isr_ctrl.sv -----
// Controller state machine for the integer square root block.
// Sequences the bisection rounds and owns both handshakes.
// Depends on isr_pkg.
module isr_ctrl
   import isr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // State register and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = status.trivial ? S_DONE : S_MID;
         end
         S_MID:  state_in = S_SQR;
         S_SQR:  state_in = status.adjacent ? S_DONE : S_CMP;
         S_CMP:  state_in = status.equal ? S_DONE : S_MID;
         S_DONE: begin
            if (cmd.out_load) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Commands and ready
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         S_MID:  cmd.calc_mid = 1'b1;
         S_SQR:  cmd.square   = 1'b1;
         S_CMP:  cmd.update   = !status.equal;
         S_DONE: cmd.out_load = !rsp_valid_ff || rsp_ready;
         default: cmd = '0;
      endcase
   end

   // Output beat held until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load)   rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- hdl/isr_dpath.sv -----
// Datapath for the integer square root block: bounds, midpoint,
// half-width squarer, comparator and output register.
// Depends on isr_pkg.
module isr_dpath
   import isr_pkg::*;
#(
   parameter int unsigned WIDTH = WIDTH_DEF
) (
   input  logic                clock,
   input  logic [VALUE_W-1:0]  req_value,
   input  cmd_type             cmd,
   output status_type          status,
   output logic [ROOT_W-1:0]   rsp_root
);

   // Midpoints at or above 2^HALF_W always square past any radicand
   localparam int unsigned HALF_W = (WIDTH + 1) / 2;
   localparam int unsigned SQ_W   = 2 * HALF_W;

   logic [WIDTH-1:0]  value_w;
   logic [WIDTH-1:0]  x_ff, lo_ff, hi_ff, mid_ff;
   logic [WIDTH-1:0]  lo_in, hi_in, mid_in;
   logic [WIDTH-1:0]  diff;
   logic              adj_ff, adj_in;
   logic [SQ_W-1:0]   sq_ff, sq_in;
   logic              over_ff, over_in;
   logic [HALF_W-1:0] mid_lo;
   logic [SQ_W-1:0]   x_wide;
   logic              less;
   logic [ROOT_W-1:0] root_ff, root_in;

   assign value_w = WIDTH'(req_value);

   // Midpoint and adjacency from current bounds
   assign diff = hi_ff - lo_ff;

   always_comb begin
      lo_in  = lo_ff;
      hi_in  = hi_ff;
      mid_in = mid_ff;
      adj_in = adj_ff;
      if (cmd.load) begin
         lo_in  = '0;
         hi_in  = value_w;
         mid_in = value_w;  // answer for radicands 0 and 1
      end else if (cmd.calc_mid) begin
         mid_in = lo_ff + (diff >> 1);
         adj_in = (diff <= WIDTH'(1));
      end else if (cmd.update) begin
         if (less) lo_in = mid_ff;
         else      hi_in = mid_ff;
      end
   end

   // Square of the low half of the midpoint
   assign mid_lo  = mid_ff[HALF_W-1:0];
   assign sq_in   = cmd.square ? SQ_W'(mid_lo * mid_lo) : sq_ff;
   assign over_in = cmd.square ? (|(mid_ff >> HALF_W)) : over_ff;

   // Compare square against radicand
   assign x_wide       = SQ_W'(x_ff);
   assign less         = !over_ff && (sq_ff < x_wide);
   assign status.equal = !over_ff && (sq_ff == x_wide);
   assign status.adjacent = adj_ff;
   assign status.trivial  = (value_w <= WIDTH'(1));

   // Output register
   assign root_in = cmd.out_load ? ROOT_W'(mid_ff) : root_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) x_ff <= value_w;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      mid_ff  <= mid_in;
      adj_ff  <= adj_in;
      sq_ff   <= sq_in;
      over_ff <= over_in;
      root_ff <= root_in;
   end

   assign rsp_root = root_ff;

endmodule

// ----- hdl/integer_square_root.sv -----
// Integer square root by bisection of [0, radicand].
// Sequence: radicands 0 and 1 go straight to the output; otherwise rounds of midpoint,
// square and compare run until the bounds are adjacent or the square matches; up to WIDTH+1 rounds.
// Throughput: one radicand at a time; the round loop through the single
// half-width squarer sets the rate. A new radicand may enter while a result waits.
// Reset: synchronous, active high; controller idle and output empty.
module integer_square_root
   import isr_pkg::*;
#(
   parameter int unsigned WIDTH = WIDTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [VALUE_W-1:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [ROOT_W-1:0]  rsp_root
);

   cmd_type    cmd;
   status_type status;

   // Sequencer
   isr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Bounds, squarer, compare, output register
   isr_dpath #(
      .WIDTH (WIDTH)
   ) u_dpath (
      .clock     (clock),
      .req_value (req_value),
      .cmd       (cmd),
      .status    (status),
      .rsp_root  (rsp_root)
   );

   // An accepted beat starts work; no second beat enters next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken on consecutive cycles");

   // Loading the answer always presents a result beat
   a_out_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid)
      else $error("answer loaded without result valid");

   // Load is never issued together with a midpoint, square or bound-update command
   a_cmd_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.load && (cmd.update || cmd.calc_mid || cmd.square)))
      else $error("conflicting datapath commands");

endmodule
